// ----- sv/esc_pkg.sv -----
// shared types, operand codes and the compensation microprogram for the sensor compensation unit
package esc_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned REG_N    = 8;
    localparam int unsigned REG_W    = $clog2(REG_N);
    localparam int unsigned PC_W     = 7;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned SHAMT_W  = 6;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned IN_W     = 64;
    localparam int unsigned OUT_W    = 72;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_TEMP_CALIB   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PRESS_LOW    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PRESS_HIGH   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_PRESS_NINE   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_HUM_CALIB    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_HUM_SIX      = 3'd5;

    // program entry points
    localparam logic [PC_W-1:0] PC_PRESS = 7'd18;
    localparam logic [PC_W-1:0] PC_HUM   = 7'd53;
    localparam logic [PC_W-1:0] PC_DONE  = 7'd81;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_SHL,
        OP_ASR,
        OP_ASR32,
        OP_MUL,
        OP_DIV,
        OP_SETF,
        OP_OUTT,
        OP_OUTP,
        OP_OUTH,
        OP_JT,
        OP_JP,
        OP_JH,
        OP_JZ,
        OP_DONE
    } op_t;

    typedef enum logic [5:0] {
        S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7,
        S_ZERO, S_ADCT, S_ADCP, S_ADCH, S_FINE,
        S_T1, S_T2, S_T3,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
        S_C128000, S_C1048576, S_C3125, S_C76800, S_C16384,
        S_C32768, S_C2097152, S_C8192, S_C128, S_C5, S_C2P47
    } src_t;

    typedef struct packed {
        op_t              op;
        logic [REG_W-1:0] dst;
        src_t             sa;
        src_t             sb;
        logic [PC_W-1:0]  imm;
    } instr_t;

    function automatic instr_t mk(op_t op, logic [REG_W-1:0] dst, src_t sa, src_t sb,
                                  logic [PC_W-1:0] imm);
        instr_t i;
        i.op  = op;
        i.dst = dst;
        i.sa  = sa;
        i.sb  = sb;
        i.imm = imm;
        return i;
    endfunction

    // microprogram: temperature, pressure, humidity in turn
    function automatic instr_t rom(logic [PC_W-1:0] pc);
        instr_t i;
        i = mk(OP_DONE, 3'd0, S_ZERO, S_ZERO, 7'd0);
        unique case (pc)
            // temperature
            7'd0:  i = mk(OP_JT,   3'd0, S_ZERO, S_ZERO, PC_PRESS);
            7'd1:  i = mk(OP_ASR,  3'd0, S_ADCT, S_ZERO, 7'd3);
            7'd2:  i = mk(OP_SHL,  3'd1, S_T1,   S_ZERO, 7'd1);
            7'd3:  i = mk(OP_SUB,  3'd0, S_R0,   S_R1,   7'd0);
            7'd4:  i = mk(OP_MUL,  3'd0, S_R0,   S_T2,   7'd0);
            7'd5:  i = mk(OP_ASR,  3'd0, S_R0,   S_ZERO, 7'd11);
            7'd6:  i = mk(OP_ASR,  3'd1, S_ADCT, S_ZERO, 7'd4);
            7'd7:  i = mk(OP_SUB,  3'd1, S_R1,   S_T1,   7'd0);
            7'd8:  i = mk(OP_MUL,  3'd1, S_R1,   S_R1,   7'd0);
            7'd9:  i = mk(OP_ASR,  3'd1, S_R1,   S_ZERO, 7'd12);
            7'd10: i = mk(OP_MUL,  3'd1, S_R1,   S_T3,   7'd0);
            7'd11: i = mk(OP_ASR,  3'd1, S_R1,   S_ZERO, 7'd14);
            7'd12: i = mk(OP_ADD,  3'd0, S_R0,   S_R1,   7'd0);
            7'd13: i = mk(OP_SETF, 3'd0, S_R0,   S_ZERO, 7'd0);
            7'd14: i = mk(OP_MUL,  3'd0, S_R0,   S_C5,   7'd0);
            7'd15: i = mk(OP_ADD,  3'd0, S_R0,   S_C128, 7'd0);
            7'd16: i = mk(OP_ASR,  3'd0, S_R0,   S_ZERO, 7'd8);
            7'd17: i = mk(OP_OUTT, 3'd0, S_R0,   S_ZERO, 7'd0);
            // pressure
            7'd18: i = mk(OP_JP,   3'd0, S_ZERO, S_ZERO, PC_HUM);
            7'd19: i = mk(OP_SUB,  3'd0, S_FINE, S_C128000, 7'd0);
            7'd20: i = mk(OP_MUL,  3'd1, S_R0,   S_R0,   7'd0);
            7'd21: i = mk(OP_MUL,  3'd2, S_R1,   S_P6,   7'd0);
            7'd22: i = mk(OP_MUL,  3'd3, S_R0,   S_P5,   7'd0);
            7'd23: i = mk(OP_SHL,  3'd3, S_R3,   S_ZERO, 7'd17);
            7'd24: i = mk(OP_ADD,  3'd2, S_R2,   S_R3,   7'd0);
            7'd25: i = mk(OP_SHL,  3'd3, S_P4,   S_ZERO, 7'd35);
            7'd26: i = mk(OP_ADD,  3'd2, S_R2,   S_R3,   7'd0);
            7'd27: i = mk(OP_MUL,  3'd1, S_R1,   S_P3,   7'd0);
            7'd28: i = mk(OP_ASR,  3'd1, S_R1,   S_ZERO, 7'd8);
            7'd29: i = mk(OP_MUL,  3'd3, S_R0,   S_P2,   7'd0);
            7'd30: i = mk(OP_SHL,  3'd3, S_R3,   S_ZERO, 7'd12);
            7'd31: i = mk(OP_ADD,  3'd1, S_R1,   S_R3,   7'd0);
            7'd32: i = mk(OP_ADD,  3'd1, S_R1,   S_C2P47, 7'd0);
            7'd33: i = mk(OP_MUL,  3'd1, S_R1,   S_P1,   7'd0);
            7'd34: i = mk(OP_ASR,  3'd1, S_R1,   S_ZERO, 7'd33);
            7'd35: i = mk(OP_JZ,   3'd0, S_R1,   S_ZERO, PC_HUM);
            7'd36: i = mk(OP_SUB,  3'd0, S_C1048576, S_ADCP, 7'd0);
            7'd37: i = mk(OP_SHL,  3'd0, S_R0,   S_ZERO, 7'd31);
            7'd38: i = mk(OP_SUB,  3'd0, S_R0,   S_R2,   7'd0);
            7'd39: i = mk(OP_MUL,  3'd0, S_R0,   S_C3125, 7'd0);
            7'd40: i = mk(OP_DIV,  3'd0, S_R0,   S_R1,   7'd0);
            7'd41: i = mk(OP_ASR,  3'd3, S_R0,   S_ZERO, 7'd13);
            7'd42: i = mk(OP_MUL,  3'd4, S_R3,   S_P9,   7'd0);
            7'd43: i = mk(OP_MUL,  3'd4, S_R4,   S_R3,   7'd0);
            7'd44: i = mk(OP_ASR,  3'd4, S_R4,   S_ZERO, 7'd25);
            7'd45: i = mk(OP_MUL,  3'd5, S_R0,   S_P8,   7'd0);
            7'd46: i = mk(OP_ASR,  3'd5, S_R5,   S_ZERO, 7'd19);
            7'd47: i = mk(OP_ADD,  3'd0, S_R0,   S_R4,   7'd0);
            7'd48: i = mk(OP_ADD,  3'd0, S_R0,   S_R5,   7'd0);
            7'd49: i = mk(OP_ASR,  3'd0, S_R0,   S_ZERO, 7'd8);
            7'd50: i = mk(OP_SHL,  3'd6, S_P7,   S_ZERO, 7'd4);
            7'd51: i = mk(OP_ADD,  3'd0, S_R0,   S_R6,   7'd0);
            7'd52: i = mk(OP_OUTP, 3'd0, S_R0,   S_ZERO, 7'd0);
            // humidity, 32-bit wrapping arithmetic
            7'd53: i = mk(OP_JH,   3'd0, S_ZERO, S_ZERO, PC_DONE);
            7'd54: i = mk(OP_SUB,  3'd0, S_FINE, S_C76800, 7'd0);
            7'd55: i = mk(OP_SHL,  3'd1, S_ADCH, S_ZERO, 7'd14);
            7'd56: i = mk(OP_SHL,  3'd2, S_H4,   S_ZERO, 7'd20);
            7'd57: i = mk(OP_SUB,  3'd1, S_R1,   S_R2,   7'd0);
            7'd58: i = mk(OP_MUL,  3'd2, S_R0,   S_H5,   7'd0);
            7'd59: i = mk(OP_SUB,  3'd1, S_R1,   S_R2,   7'd0);
            7'd60: i = mk(OP_ADD,  3'd1, S_R1,   S_C16384, 7'd0);
            7'd61: i = mk(OP_ASR32, 3'd1, S_R1,  S_ZERO, 7'd15);
            7'd62: i = mk(OP_MUL,  3'd2, S_R0,   S_H6,   7'd0);
            7'd63: i = mk(OP_ASR32, 3'd2, S_R2,  S_ZERO, 7'd10);
            7'd64: i = mk(OP_MUL,  3'd3, S_R0,   S_H3,   7'd0);
            7'd65: i = mk(OP_ASR32, 3'd3, S_R3,  S_ZERO, 7'd11);
            7'd66: i = mk(OP_ADD,  3'd3, S_R3,   S_C32768, 7'd0);
            7'd67: i = mk(OP_MUL,  3'd2, S_R2,   S_R3,   7'd0);
            7'd68: i = mk(OP_ASR32, 3'd2, S_R2,  S_ZERO, 7'd10);
            7'd69: i = mk(OP_ADD,  3'd2, S_R2,   S_C2097152, 7'd0);
            7'd70: i = mk(OP_MUL,  3'd2, S_R2,   S_H2,   7'd0);
            7'd71: i = mk(OP_ADD,  3'd2, S_R2,   S_C8192, 7'd0);
            7'd72: i = mk(OP_ASR32, 3'd2, S_R2,  S_ZERO, 7'd14);
            7'd73: i = mk(OP_MUL,  3'd1, S_R1,   S_R2,   7'd0);
            7'd74: i = mk(OP_ASR32, 3'd2, S_R1,  S_ZERO, 7'd15);
            7'd75: i = mk(OP_MUL,  3'd2, S_R2,   S_R2,   7'd0);
            7'd76: i = mk(OP_ASR32, 3'd2, S_R2,  S_ZERO, 7'd7);
            7'd77: i = mk(OP_MUL,  3'd2, S_R2,   S_H1,   7'd0);
            7'd78: i = mk(OP_ASR32, 3'd2, S_R2,  S_ZERO, 7'd4);
            7'd79: i = mk(OP_SUB,  3'd1, S_R1,   S_R2,   7'd0);
            7'd80: i = mk(OP_OUTH, 3'd0, S_R1,   S_ZERO, 7'd0);
            default: i = mk(OP_DONE, 3'd0, S_ZERO, S_ZERO, 7'd0);
        endcase
        return i;
    endfunction

endpackage

// ----- sv/environmental_sensor_compensation_unit.sv -----
// top level of the environmental sensor compensation unit: sequencer, serial multiplier and divider
//
// One input transfer on the s_ group carries a set of raw temperature, pressure and
// humidity conversions with a skipped flag each. The block runs a fixed microprogram
// over a bank of eight 64-bit working registers, using one shift-and-add multiplier
// that retires one multiplier bit per cycle and one restoring divider that yields one
// quotient bit per cycle. One result transfer on the m_ group follows each input.
// A multiply stops early once the remaining multiplier bits are all zeros or all ones;
// skipped readings shorten the run of a set. One set is worked on at a time; s_tready
// is high while the sequencer is idle, also while a finished result still waits in the
// output register. If the receiver stalls, the next set may run but its result is held
// until the output register is free. The user must write the calibration words through
// cfg_we, cfg_addr, cfg_data only while the block is idle; the block itself does not
// enforce this. Reset clears the calibration words, the kept fine temperature and all
// handshake state.
module environmental_sensor_compensation_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [esc_pkg::IDX_W-1:0]     cfg_addr,
    input  logic [esc_pkg::WORD_W-1:0]    cfg_data,
    // raw readings
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // adc_temp[19:0], temp_skipped[20], adc_press[40:21], press_skipped[41],
    // adc_hum[57:42], hum_skipped[58], zero fill [63:59]
    input  logic [esc_pkg::IN_W-1:0]      s_tdata,
    // compensated results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // temp_centi[15:0], temp_ok[16], press_q24_8[48:17], press_ok[49],
    // hum_q7_10[66:50], hum_ok[67], zero fill [71:68]
    output logic [esc_pkg::OUT_W-1:0]     m_tdata
);
    import esc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t             state_reg;
    logic [PC_W-1:0]    pc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [WORD_W-1:0]  acc_reg;
    logic [WORD_W-1:0]  ma_reg;
    logic [WORD_W-1:0]  mb_reg;
    logic               neg_reg;
    logic [WORD_W-1:0]  wr_reg [REG_N];

    // calibration words
    logic [47:0]        temp_calib_reg;
    logic [63:0]        press_low_reg;
    logic [63:0]        press_high_reg;
    logic [15:0]        press_nine_reg;
    logic [55:0]        hum_calib_reg;
    logic [7:0]         hum_six_reg;
    logic [31:0]        fine_reg;

    // latched input set
    logic [19:0]        adc_t_reg;
    logic [19:0]        adc_p_reg;
    logic [15:0]        adc_h_reg;
    logic               skip_t_reg;
    logic               skip_p_reg;
    logic               skip_h_reg;

    // result being built
    logic [15:0]        temp_res_reg;
    logic               temp_ok_reg;
    logic [31:0]        press_res_reg;
    logic               press_ok_reg;
    logic [16:0]        hum_res_reg;
    logic               hum_ok_reg;

    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    instr_t             ins;
    logic [WORD_W-1:0]  a_val;
    logic [WORD_W-1:0]  b_val;
    logic [SHAMT_W-1:0] shamt;
    logic [WORD_W-1:0]  a_sx32;
    logic [WORD_W-1:0]  mul_sum;
    logic [WORD_W-1:0]  mul_dif;
    logic [WORD_W:0]    rem_sh;
    logic               rem_ge;
    logic [WORD_W-1:0]  quo_next;
    logic [WORD_W-1:0]  rem_next;
    logic [31:0]        hum_v;
    logic [PC_W-1:0]    pc_next;
    logic               in_xfer;
    logic               out_free;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // operand select
    function automatic logic [WORD_W-1:0] pick(src_t s);
        logic [WORD_W-1:0] v;
        unique case (s)
            S_R0:       v = wr_reg[0];
            S_R1:       v = wr_reg[1];
            S_R2:       v = wr_reg[2];
            S_R3:       v = wr_reg[3];
            S_R4:       v = wr_reg[4];
            S_R5:       v = wr_reg[5];
            S_R6:       v = wr_reg[6];
            S_R7:       v = wr_reg[7];
            S_ZERO:     v = '0;
            S_ADCT:     v = {44'd0, adc_t_reg};
            S_ADCP:     v = {44'd0, adc_p_reg};
            S_ADCH:     v = {48'd0, adc_h_reg};
            S_FINE:     v = {{32{fine_reg[31]}}, fine_reg};
            S_T1:       v = {48'd0, temp_calib_reg[15:0]};
            S_T2:       v = {{48{temp_calib_reg[31]}}, temp_calib_reg[31:16]};
            S_T3:       v = {{48{temp_calib_reg[47]}}, temp_calib_reg[47:32]};
            S_P1:       v = {48'd0, press_low_reg[15:0]};
            S_P2:       v = {{48{press_low_reg[31]}}, press_low_reg[31:16]};
            S_P3:       v = {{48{press_low_reg[47]}}, press_low_reg[47:32]};
            S_P4:       v = {{48{press_low_reg[63]}}, press_low_reg[63:48]};
            S_P5:       v = {{48{press_high_reg[15]}}, press_high_reg[15:0]};
            S_P6:       v = {{48{press_high_reg[31]}}, press_high_reg[31:16]};
            S_P7:       v = {{48{press_high_reg[47]}}, press_high_reg[47:32]};
            S_P8:       v = {{48{press_high_reg[63]}}, press_high_reg[63:48]};
            S_P9:       v = {{48{press_nine_reg[15]}}, press_nine_reg};
            S_H1:       v = {56'd0, hum_calib_reg[7:0]};
            S_H2:       v = {{48{hum_calib_reg[23]}}, hum_calib_reg[23:8]};
            S_H3:       v = {56'd0, hum_calib_reg[31:24]};
            S_H4:       v = {{52{hum_calib_reg[43]}}, hum_calib_reg[43:32]};
            S_H5:       v = {{52{hum_calib_reg[55]}}, hum_calib_reg[55:44]};
            S_H6:       v = {{56{hum_six_reg[7]}}, hum_six_reg};
            S_C128000:  v = 64'd128000;
            S_C1048576: v = 64'd1048576;
            S_C3125:    v = 64'd3125;
            S_C76800:   v = 64'd76800;
            S_C16384:   v = 64'd16384;
            S_C32768:   v = 64'd32768;
            S_C2097152: v = 64'd2097152;
            S_C8192:    v = 64'd8192;
            S_C128:     v = 64'd128;
            S_C5:       v = 64'd5;
            S_C2P47:    v = 64'h0000_8000_0000_0000;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // decode and operand fetch
    always_comb
    begin
        ins    = rom(pc_reg);
        a_val  = pick(ins.sa);
        b_val  = pick(ins.sb);
        shamt  = ins.imm[SHAMT_W-1:0];
        a_sx32 = {{32{a_val[31]}}, a_val[31:0]};
    end

    // next program step: branches, or hold on a multiply, a divide or the done step
    always_comb
    begin
        pc_next = pc_reg + 1'b1;
        unique case (ins.op)
            OP_JT:   if (skip_t_reg) pc_next = ins.imm;
            OP_JP:   if (skip_p_reg) pc_next = ins.imm;
            OP_JH:   if (skip_h_reg) pc_next = ins.imm;
            OP_JZ:   if (a_val == '0) pc_next = ins.imm;
            OP_MUL, OP_DIV, OP_DONE: pc_next = pc_reg;
            default: ;
        endcase
    end

    // multiplier and divider step logic
    always_comb
    begin
        mul_sum  = acc_reg + ma_reg;
        mul_dif  = acc_reg - ma_reg;
        rem_sh   = {acc_reg, ma_reg[WORD_W-1]};
        rem_ge   = (rem_sh >= {1'b0, mb_reg});
        rem_next = rem_ge ? (rem_sh[WORD_W-1:0] - mb_reg) : rem_sh[WORD_W-1:0];
        quo_next = {ma_reg[WORD_W-2:0], rem_ge};
        hum_v    = a_val[31:0];
    end

    // sequencer, working registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_nine_reg <= '0;
            hum_calib_reg  <= '0;
            hum_six_reg    <= '0;
            fine_reg       <= '0;
            temp_ok_reg    <= 1'b0;
            press_ok_reg   <= 1'b0;
            hum_ok_reg     <= 1'b0;
        end
        else
        begin
            // calibration writes
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_TEMP_CALIB: temp_calib_reg <= cfg_data[47:0];
                    CFG_PRESS_LOW:  press_low_reg  <= cfg_data;
                    CFG_PRESS_HIGH: press_high_reg <= cfg_data;
                    CFG_PRESS_NINE: press_nine_reg <= cfg_data[15:0];
                    CFG_HUM_CALIB:  hum_calib_reg  <= cfg_data[55:0];
                    CFG_HUM_SIX:    hum_six_reg    <= cfg_data[7:0];
                    default:        ;
                endcase
            end

            // output transfer taken, unless the hold state reloads it
            if (m_tvalid_reg && m_tready && (state_reg != ST_HOLD))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        adc_t_reg     <= s_tdata[19:0];
                        skip_t_reg    <= s_tdata[20];
                        adc_p_reg     <= s_tdata[40:21];
                        skip_p_reg    <= s_tdata[41];
                        adc_h_reg     <= s_tdata[57:42];
                        skip_h_reg    <= s_tdata[58];
                        temp_res_reg  <= '0;
                        press_res_reg <= '0;
                        hum_res_reg   <= '0;
                        temp_ok_reg   <= 1'b0;
                        press_ok_reg  <= 1'b0;
                        hum_ok_reg    <= 1'b0;
                        pc_reg        <= '0;
                        state_reg     <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    pc_reg <= pc_next;
                    unique case (ins.op)
                        OP_ADD:   wr_reg[ins.dst] <= a_val + b_val;
                        OP_SUB:   wr_reg[ins.dst] <= a_val - b_val;
                        OP_SHL:   wr_reg[ins.dst] <= a_val << shamt;
                        OP_ASR:   wr_reg[ins.dst] <= $signed(a_val) >>> shamt;
                        OP_ASR32: wr_reg[ins.dst] <= $signed(a_sx32) >>> shamt;
                        OP_MUL:
                        begin
                            acc_reg   <= '0;
                            ma_reg    <= a_val;
                            mb_reg    <= b_val;
                            state_reg <= ST_MUL;
                        end
                        OP_DIV:
                        begin
                            acc_reg   <= '0;
                            ma_reg    <= a_val[WORD_W-1] ? (64'd0 - a_val) : a_val;
                            mb_reg    <= b_val[WORD_W-1] ? (64'd0 - b_val) : b_val;
                            neg_reg   <= a_val[WORD_W-1] ^ b_val[WORD_W-1];
                            cnt_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                        OP_SETF:  fine_reg <= a_val[31:0];
                        OP_OUTT:
                        begin
                            temp_ok_reg <= 1'b1;
                            priority if ($signed(a_val) > $signed(64'd32767))
                                temp_res_reg <= 16'h7FFF;
                            else if ($signed(a_val) < $signed(-64'sd32768))
                                temp_res_reg <= 16'h8000;
                            else
                                temp_res_reg <= a_val[15:0];
                        end
                        OP_OUTP:
                        begin
                            press_ok_reg <= 1'b1;
                            priority if (a_val[WORD_W-1])
                                press_res_reg <= '0;
                            else if (a_val[62:32] != '0)
                                press_res_reg <= '1;
                            else
                                press_res_reg <= a_val[31:0];
                        end
                        OP_OUTH:
                        begin
                            hum_ok_reg <= 1'b1;
                            priority if (hum_v[31])
                                hum_res_reg <= '0;
                            else if (hum_v > HUM_MAX)
                                hum_res_reg <= HUM_MAX[28:12];
                            else
                                hum_res_reg <= hum_v[28:12];
                        end
                        OP_DONE:  state_reg <= ST_HOLD;
                        default:  ;
                    endcase
                end
                ST_MUL:
                begin
                    // one multiplier bit per cycle, early stop on sign fill
                    priority if (mb_reg == '0)
                    begin
                        wr_reg[ins.dst] <= acc_reg;
                        pc_reg          <= pc_reg + 1'b1;
                        state_reg       <= ST_EXEC;
                    end
                    else if (mb_reg == '1)
                    begin
                        wr_reg[ins.dst] <= mul_dif;
                        pc_reg          <= pc_reg + 1'b1;
                        state_reg       <= ST_EXEC;
                    end
                    else
                    begin
                        if (mb_reg[0])
                            acc_reg <= mul_sum;
                        ma_reg <= ma_reg << 1;
                        mb_reg <= $signed(mb_reg) >>> 1;
                    end
                end
                ST_DIV:
                begin
                    // one quotient bit per cycle
                    acc_reg <= rem_next;
                    ma_reg  <= quo_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WORD_W - 1))
                    begin
                        wr_reg[ins.dst] <= neg_reg ? (64'd0 - quo_next) : quo_next;
                        pc_reg          <= pc_reg + 1'b1;
                        state_reg       <= ST_EXEC;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, hum_ok_reg, hum_res_reg, press_ok_reg,
                                         press_res_reg, temp_ok_reg, temp_res_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // an accepted set always starts the program at its first step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_EXEC) && (pc_reg == '0))
        else $error("program did not start after input transfer");

    // the divider step counter stays below the word width while dividing
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(WORD_W)))
        else $error("divider step count out of range");

    // a new result is only loaded from the hold state
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("result loaded outside hold state");

    // the program counter never runs past its last step
    a_pc: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_DONE)
        else $error("program counter out of range");

endmodule
